/* rtl/sorted_priority_queue_top_assert.svh */
// Assertion macros for the sorted priority queue checker.
// Used by spq_checker; expects clk and rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

    localparam int KEY_W        = 32;
    localparam int REQ_W        = 2;
    localparam int ST_W         = 2;
    localparam int OCC_W        = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 2'd0,
        REQ_PEEK    = 2'd1,
        REQ_EXTRACT = 2'd2
    } req_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } ctl_state_t;

    typedef struct packed {
        logic    load;
        logic    insert;
        logic    extract;
        logic    result;
        logic    take_min;
        status_t st;
    } spq_cmd_t;

    typedef struct packed {
        logic is_insert;
        logic is_peek;
        logic is_extract;
        logic full;
        logic empty;
    } spq_stat_t;

endpackage
`default_nettype wire

/* rtl/spq_datapath.sv */
// Datapath: sorted key cell array, key count, request and result registers.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [spq_pkg::REQ_W-1:0]    req_type,
    input  wire logic signed [spq_pkg::KEY_W-1:0] key,
    input  wire spq_pkg::spq_cmd_t            cmd,
    output spq_pkg::spq_stat_t                stat,
    output logic signed [spq_pkg::KEY_W-1:0]  min_key,
    output logic [spq_pkg::ST_W-1:0]          status,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [KEY_W-1:0] cell_reg [CAPACITY];
    logic signed [KEY_W-1:0] cell_next [CAPACITY];
    logic [CAPACITY-1:0]     gt;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [REQ_W-1:0]        req_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] min_key_reg;
    logic [ST_W-1:0]         status_reg;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CNT_W'(i) < count_reg)
                gt[i] = cell_reg[i] > key_reg;
            else
                gt[i] = (CNT_W'(i) == count_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.insert)
            begin
                if (gt[i])
                begin
                    if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                        cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                    else
                        cell_next[i] = key_reg;
                end
            end
            else if (cmd.extract)
            begin
                if (i < CAPACITY - 1)
                    cell_next[i] = cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.extract)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            cell_reg[i] <= cell_next[i];
        if (cmd.load)
        begin
            req_reg <= req_type;
            key_reg <= key;
        end
        if (cmd.result)
        begin
            min_key_reg <= cmd.take_min ? cell_reg[0] : '0;
            status_reg  <= cmd.st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign stat.is_insert  = (req_reg == REQ_INSERT);
    assign stat.is_peek    = (req_reg == REQ_PEEK);
    assign stat.is_extract = (req_reg == REQ_EXTRACT);
    assign stat.full       = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty      = (count_reg == '0);

    assign min_key   = min_key_reg;
    assign status    = status_reg;
    assign occupancy = OCC_W'(count_reg);

endmodule
`default_nettype wire

/* rtl/spq_ctrl.sv */
// Controller: accept, execute and respond sequence for one item at a time.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t       cmd
);
    import spq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_EXEC;
            S_EXEC:  state_next = S_RESP;
            S_RESP:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd          = '0;
        cmd.st       = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.result = 1'b1;
                priority if (stat.is_insert)
                begin
                    if (stat.full)
                        cmd.st = ST_FULL;
                    else
                        cmd.insert = 1'b1;
                end
                else if (stat.is_peek || stat.is_extract)
                begin
                    if (stat.empty)
                        cmd.st = ST_EMPTY;
                    else
                    begin
                        cmd.take_min = 1'b1;
                        cmd.extract  = stat.is_extract;
                    end
                end
                else
                begin
                    cmd.st = ST_OK;
                end
            end
            S_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/sorted_priority_queue_top.sv */
// Sorted priority queue: one request per item, one result per request; each
// item passes through accept, execute and present states, the present state
// held through any output stall. The whole cell array compares against the
// new key and shifts in the execute state, so the per-item time does not grow
// with CAPACITY; the next item is accepted only after the result has been
// taken. Top level; depends on spq_pkg, spq_ctrl and spq_datapath.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [spq_pkg::REQ_W-1:0]        req_type,
    input  wire logic signed [spq_pkg::KEY_W-1:0] key,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [spq_pkg::KEY_W-1:0]      min_key,
    output logic [spq_pkg::ST_W-1:0]              status,
    output logic [spq_pkg::OCC_W-1:0]             occupancy
);
    import spq_pkg::*;

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_type  (req_type),
        .key       (key),
        .cmd       (cmd),
        .stat      (stat),
        .min_key   (min_key),
        .status    (status),
        .occupancy (occupancy)
    );

endmodule
`default_nettype wire

/* rtl/spq_checker.sv */
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_top_assert.svh"
module spq_checker #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic signed [spq_pkg::KEY_W-1:0] min_key,
    input wire logic [spq_pkg::ST_W-1:0]         status,
    input wire logic [spq_pkg::OCC_W-1:0]        occupancy
);
    import spq_pkg::*;

    `SPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(min_key) && $stable(status) && $stable(occupancy), "result changed while stalled")
    `SPQ_ASSERT_NOW(a_one_item, in_ready, !out_valid, "input taken while a result is pending")
    `SPQ_ASSERT_NOW(a_empty_res, out_valid && status == ST_EMPTY, occupancy == '0 && min_key == '0, "empty status with keys held")
    `SPQ_ASSERT_NOW(a_full_res, out_valid && status == ST_FULL, occupancy == OCC_W'(CAPACITY) && min_key == '0, "full status below capacity")
    `SPQ_ASSERT_NEXT(a_in_take, in_valid && in_ready, !in_ready && !out_valid, "second item taken before the first completed")

endmodule

bind sorted_priority_queue_top spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_key   (min_key),
    .status    (status),
    .occupancy (occupancy)
);
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for sorted_priority_queue_top: random and directed
// insert, peek, extract and unused requests against a mirrored sorted key list.
// Depends on spq_pkg and the RTL of sorted_priority_queue_top.
`timescale 1ns / 1ps
module tb_top;
    import spq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int LONG_HOLD_CYCLES = 300;

    class spq_scoreboard;
        typedef struct {
            logic signed [KEY_W-1:0] min_key;
            logic [ST_W-1:0]         status;
            logic [OCC_W-1:0]        occupancy;
        } reply_t;

        logic signed [KEY_W-1:0] mirror_keys[$];
        reply_t                  reply_fifo[$];
        int errors;
        int replies_checked;
        int full_hits;
        int empty_hits;

        function void apply_request(logic [REQ_W-1:0] req, logic signed [KEY_W-1:0] k);
            reply_t r;
            int pos;
            r.min_key = '0;
            r.status  = ST_OK;
            if (req == REQ_INSERT) begin
                if (mirror_keys.size() >= CAPACITY_DEF) begin
                    r.status = ST_FULL;
                    full_hits++;
                end else begin
                    pos = 0;
                    while (pos < mirror_keys.size() && mirror_keys[pos] <= k)
                        pos++;
                    mirror_keys.insert(pos, k);
                end
            end else if (req == REQ_PEEK || req == REQ_EXTRACT) begin
                if (mirror_keys.size() == 0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    r.min_key = mirror_keys[0];
                    if (req == REQ_EXTRACT)
                        void'(mirror_keys.pop_front());
                end
            end
            r.occupancy = OCC_W'(mirror_keys.size());
            reply_fifo.push_back(r);
        endfunction

        function void check_reply(logic signed [KEY_W-1:0] mk, logic [ST_W-1:0] st,
                                  logic [OCC_W-1:0] occ);
            reply_t r;
            if (reply_fifo.size() == 0) begin
                $display("%0t: reply with none pending: min_key %0d status %0d occupancy %0d",
                         $time, mk, st, occ);
                errors++;
                return;
            end
            r = reply_fifo.pop_front();
            replies_checked++;
            if (mk !== r.min_key) begin
                $display("%0t: min_key mismatch: expected %0d, actual %0d",
                         $time, r.min_key, mk);
                errors++;
            end
            if (st !== r.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, r.status, st);
                errors++;
            end
            if (occ !== r.occupancy) begin
                $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                         $time, r.occupancy, occ);
                errors++;
            end
        endfunction

        function int outstanding();
            return reply_fifo.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [KEY_W-1:0] key;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [KEY_W-1:0] min_key;
    logic [ST_W-1:0]         status;
    logic [OCC_W-1:0]        occupancy;

    spq_scoreboard sb;
    int items_sent;
    int idle_cycles = 0;
    bit sender_quiet;

    sorted_priority_queue_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .min_key   (min_key),
        .status    (status),
        .occupancy (occupancy)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $signed($urandom_range(0, 8)) - 4;
        if (r < 45)
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        return $urandom();
    endfunction

    task automatic send_item(logic [REQ_W-1:0] req, logic signed [KEY_W-1:0] k, int gap);
        in_valid <= 1'b1;
        req_type <= req;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
        sb.apply_request(req, k);
        items_sent++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_random(int count);
        int done;
        int insert_pct;
        int extract_pct;
        int r;
        int phase_left;
        logic [REQ_W-1:0] req;
        done = 0;
        phase_left = 0;
        insert_pct = 50;
        extract_pct = 30;
        while (done < count) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(40, 120);
                sender_quiet = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0: begin insert_pct = 75; extract_pct = 15; end
                    1: begin insert_pct = 20; extract_pct = 60; end
                    default: begin insert_pct = 45; extract_pct = 35; end
                endcase
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (r < 3)
                req = REQ_UNUSED;
            else if (r < insert_pct)
                req = REQ_INSERT;
            else if (r < insert_pct + extract_pct)
                req = REQ_EXTRACT;
            else
                req = REQ_PEEK;
            if (done == count / 2) begin
                in_valid <= 1'b0;
                while (sb.outstanding() != 0)
                    @(posedge clk);
            end
            send_item(req, (req == REQ_INSERT) ? pick_key() : $urandom(),
                      sender_quiet ? 0 : pick_gap());
            if (req != REQ_UNUSED)
                done++;
        end
    endtask

    // receiver: random stalls, quiet stretches, one long hold-off
    initial begin
        int stall_left;
        int replies_seen;
        bit quiet;
        bit long_hold_done;
        stall_left = 0;
        replies_seen = 0;
        quiet = 1'b0;
        long_hold_done = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                sb.check_reply(min_key, status, occupancy);
                replies_seen++;
            end
            if ($urandom_range(0, 149) == 0)
                quiet = ~quiet;
            if (!long_hold_done && replies_seen == 500) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        sb = new();
        items_sent = 0;
        sender_quiet = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        req_type <= REQ_INSERT;
        key      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(REQ_PEEK, 32'sd0, 0);
        send_item(REQ_EXTRACT, 32'sh7fff_ffff, 1);
        send_item(REQ_UNUSED, 32'sh8000_0000, 0);
        send_item(REQ_INSERT, 32'sh7fff_ffff, 0);
        send_item(REQ_INSERT, 32'sh8000_0000, 2);
        send_item(REQ_INSERT, 32'sd0, 0);
        send_item(REQ_INSERT, -32'sd1, 0);
        send_item(REQ_INSERT, 32'sd0, 0);
        send_item(REQ_PEEK, 32'sd5, 0);
        send_item(REQ_UNUSED, -32'sd1, 3);
        send_item(REQ_EXTRACT, 32'sd0, 0);
        send_item(REQ_EXTRACT, 32'sd0, 0);
        send_item(REQ_PEEK, 32'sd0, 0);
        send_item(REQ_INSERT, 32'sh5555_5555, 0);
        send_item(REQ_INSERT, 32'shaaaa_aaaa, 0);
        send_item(REQ_EXTRACT, 32'sd0, 0);
        send_item(REQ_EXTRACT, 32'sd0, 0);
        send_item(REQ_EXTRACT, 32'sd0, 0);
        send_item(REQ_EXTRACT, 32'sd0, 0);
        send_item(REQ_EXTRACT, 32'sd0, 0);

        run_random(RANDOM_ITEMS);
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d items, checked %0d replies.", items_sent, sb.replies_checked);
        $display("Inserts into a full queue: %0d, reads of an empty queue: %0d.",
                 sb.full_hits, sb.empty_hits);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_datapath.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue_top.sv
rtl/spq_checker.sv
tb/tb_top.sv
